### src/sibm_pkg.sv
// Package for the scanline IRQ bank mapper: register addresses, command and
// status codes, reset values and the program bank fold-down function.
// No dependencies.
`default_nettype none

package sibm_pkg;

  localparam int BANK_BITS = 8;

  // Input command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Decoded register addresses.
  localparam logic [15:0] ADDR_CONTROL   = 16'h8000;
  localparam logic [15:0] ADDR_DATA      = 16'h8001;
  localparam logic [15:0] ADDR_MIRROR    = 16'hA000;
  localparam logic [15:0] ADDR_SRAM      = 16'hA001;
  localparam logic [15:0] ADDR_IRQ_COUNT = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_LATCH = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_OFF   = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_ON    = 16'hE001;

  // Bank command indexes held in the control byte.
  localparam logic [2:0] BANK_CMD_CHR_2K_0 = 3'd0;
  localparam logic [2:0] BANK_CMD_CHR_2K_1 = 3'd1;
  localparam logic [2:0] BANK_CMD_CHR_1K_0 = 3'd2;
  localparam logic [2:0] BANK_CMD_CHR_1K_1 = 3'd3;
  localparam logic [2:0] BANK_CMD_CHR_1K_2 = 3'd4;
  localparam logic [2:0] BANK_CMD_CHR_1K_3 = 3'd5;
  localparam logic [2:0] BANK_CMD_PRG_0    = 3'd6;
  localparam logic [2:0] BANK_CMD_PRG_1    = 3'd7;

  // Control byte bits.
  localparam int CTRL_PRG_SWAP_BIT = 6;
  localparam int CTRL_CHR_SWAP_BIT = 7;

  // Result status codes.
  localparam logic [1:0] STATUS_NONE  = 2'd0;
  localparam logic [1:0] STATUS_IRQ   = 2'd1;
  localparam logic [1:0] STATUS_FAULT = 2'd2;

  localparam logic [9:0] LINE_PRE_RENDER = 10'h3FF;
  localparam logic signed [9:0] LINE_LAST_VISIBLE = 10'sd239;

  localparam logic [7:0] PRG_COUNT_RESET = 8'd32;
  localparam logic [7:0] IRQ_LATCH_RESET = 8'hFF;

  // Keep the widest low-bit mask under which the bank falls below the count.
  // A bank already below the count passes unchanged through the full mask.
  function automatic logic [7:0] fold_bank(input logic [7:0] bank, input logic [7:0] count);
    logic [BANK_BITS-1:0] b;
    logic [BANK_BITS-1:0] mask;
    logic [BANK_BITS-1:0] result;
    b = BANK_BITS'(bank);
    result = '0;
    for (int i = 0; i <= BANK_BITS; i++) begin
      mask = BANK_BITS'((1 << i) - 1);
      if (8'(b & mask) < count) begin
        result = b & mask;
      end
    end
    return 8'(result);
  endfunction

  localparam logic [7:0] PRG_SLOT0_RESET = fold_bank(8'd0, PRG_COUNT_RESET);
  localparam logic [7:0] PRG_SLOT1_RESET = fold_bank(8'd1, PRG_COUNT_RESET);
  localparam logic [7:0] PRG_SLOT2_RESET = fold_bank(PRG_COUNT_RESET - 8'd2, PRG_COUNT_RESET);
  localparam logic [7:0] PRG_SLOT3_RESET = fold_bank(PRG_COUNT_RESET - 8'd1, PRG_COUNT_RESET);

endpackage

`default_nettype wire

### src/scanline_irq_bank_mapper_unit.sv
// Top level of the scanline IRQ bank mapper: input register, mapper state,
// decode and update logic, result register.
// Depends on sibm_pkg.
//
//   Port group     Direction  Handshake            Carries
//   in_*           in         in_valid/in_ready    bus write or scanline tick
//   out_*          out        out_valid/out_ready  bank slots, chr assignments, status
//   cfg_*          in         cfg_we               program bank count
//
// One beat in, one beat out. A beat is held in the input register and
// is decoded and applied to the mapper state as it moves to the result
// register; a beat can be taken every cycle unless the result register is stalled.
// Reset is synchronous and restores the mapper state and a bank count of 32.
// When the result register is held by out_ready low, the input register
// holds too and in_ready drops only once both are full.
`default_nettype none

module scanline_irq_bank_mapper_unit
  import sibm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,

  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              command,
  input  wire logic [15:0]       address,
  input  wire logic [7:0]        write_data,
  input  wire logic signed [9:0] scanline,
  input  wire logic              rendering_on,

  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             prg_slot0,
  output logic [7:0]             prg_slot1,
  output logic [7:0]             prg_slot2,
  output logic [7:0]             prg_slot3,
  output logic [1:0]             chr_writes,
  output logic [2:0]             chr_slot_first,
  output logic [7:0]             chr_bank_first,
  output logic [2:0]             chr_slot_second,
  output logic [7:0]             chr_bank_second,
  output logic                   mirror_horizontal,
  output logic                   sram_enable,
  output logic [1:0]             status,

  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_wdata
);

  // Input register.
  logic              s1_valid;
  logic              s1_command;
  logic [15:0]       s1_address;
  logic [7:0]        s1_data;
  logic signed [9:0] s1_scanline;
  logic              s1_render;
  logic              s1_go;

  // Mapper state.
  logic [7:0] prg_bank_count;
  logic [7:0] control_byte;
  logic       control_seen;
  logic [7:0] prg_slots [4];
  logic [7:0] irq_counter;
  logic [7:0] irq_latch;
  logic       irq_enabled;
  logic       mirror_flag;
  logic       sram_flag;

  logic [7:0] control_byte_next;
  logic       control_seen_next;
  logic [7:0] prg_slots_next [4];
  logic [7:0] irq_counter_next;
  logic [7:0] irq_latch_next;
  logic       irq_enabled_next;
  logic       mirror_flag_next;
  logic       sram_flag_next;

  logic [1:0] chr_writes_next;
  logic [2:0] chr_slot_first_next;
  logic [7:0] chr_bank_first_next;
  logic [2:0] chr_slot_second_next;
  logic [7:0] chr_bank_second_next;
  logic [1:0] status_next;

  logic [2:0] command_index;
  logic       chr_swap;
  logic       prg_swap;
  logic [7:0] data_bank;
  logic [7:0] second_last;
  logic [7:0] last_bank;
  logic [7:0] counter_dec;

  assign s1_go    = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command  <= command;
      s1_address  <= address;
      s1_data     <= write_data;
      s1_scanline <= scanline;
      s1_render   <= rendering_on;
    end
  end

  assign command_index = control_byte[2:0];
  assign chr_swap      = control_byte[CTRL_CHR_SWAP_BIT];
  assign prg_swap      = control_byte[CTRL_PRG_SWAP_BIT];
  assign data_bank     = fold_bank(s1_data, prg_bank_count);
  assign second_last   = fold_bank(prg_bank_count - 8'd2, prg_bank_count);
  assign last_bank     = fold_bank(prg_bank_count - 8'd1, prg_bank_count);
  assign counter_dec   = irq_counter - 8'd1;

  always_comb begin
    control_byte_next    = control_byte;
    control_seen_next    = control_seen;
    prg_slots_next       = prg_slots;
    irq_counter_next     = irq_counter;
    irq_latch_next       = irq_latch;
    irq_enabled_next     = irq_enabled;
    mirror_flag_next     = mirror_flag;
    sram_flag_next       = sram_flag;
    chr_writes_next      = 2'd0;
    chr_slot_first_next  = 3'd0;
    chr_bank_first_next  = 8'd0;
    chr_slot_second_next = 3'd0;
    chr_bank_second_next = 8'd0;
    status_next          = STATUS_NONE;

    if (s1_command == CMD_WRITE) begin
      case (s1_address)
        ADDR_CONTROL: begin
          control_byte_next = s1_data;
          control_seen_next = 1'b1;
        end
        ADDR_DATA: begin
          if (!control_seen) begin
            status_next = STATUS_FAULT;
          end else begin
            case (command_index)
              BANK_CMD_CHR_2K_0, BANK_CMD_CHR_2K_1: begin
                chr_writes_next      = 2'd2;
                chr_slot_first_next  = {chr_swap, command_index[0], 1'b0};
                chr_slot_second_next = {chr_swap, command_index[0], 1'b1};
                chr_bank_first_next  = s1_data;
                chr_bank_second_next = s1_data + 8'd1;
              end
              BANK_CMD_CHR_1K_0, BANK_CMD_CHR_1K_1,
              BANK_CMD_CHR_1K_2, BANK_CMD_CHR_1K_3: begin
                chr_writes_next     = 2'd1;
                chr_slot_first_next = {~chr_swap, 2'(command_index - BANK_CMD_CHR_1K_0)};
                chr_bank_first_next = s1_data;
              end
              BANK_CMD_PRG_0: begin
                if (!prg_swap) begin
                  prg_slots_next[0] = data_bank;
                  prg_slots_next[2] = second_last;
                end else begin
                  prg_slots_next[0] = second_last;
                  prg_slots_next[2] = data_bank;
                end
                prg_slots_next[3] = last_bank;
              end
              BANK_CMD_PRG_1: begin
                prg_slots_next[1] = data_bank;
                if (!prg_swap) begin
                  prg_slots_next[2] = second_last;
                end else begin
                  prg_slots_next[0] = second_last;
                end
                prg_slots_next[3] = last_bank;
              end
              default: begin
              end
            endcase
          end
        end
        ADDR_MIRROR:    mirror_flag_next = s1_data[0];
        ADDR_SRAM:      sram_flag_next   = s1_data[0];
        ADDR_IRQ_COUNT: irq_counter_next = s1_data;
        ADDR_IRQ_LATCH: irq_latch_next   = s1_data;
        ADDR_IRQ_OFF: begin
          irq_enabled_next = 1'b0;
          irq_counter_next = irq_latch;
        end
        ADDR_IRQ_ON:    irq_enabled_next = 1'b1;
        default: begin
        end
      endcase
    end else begin
      // The pre-render line reloads; visible lines count down when enabled and rendering is on.
      if (s1_scanline == LINE_PRE_RENDER) begin
        irq_counter_next = irq_latch;
      end else if (s1_scanline >= 10'sd0 && s1_scanline <= LINE_LAST_VISIBLE) begin
        if (irq_enabled && s1_render) begin
          irq_counter_next = counter_dec;
          if (counter_dec == 8'd0) begin
            status_next = STATUS_IRQ;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= PRG_COUNT_RESET;
    end else if (cfg_we) begin
      prg_bank_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_byte <= 8'd0;
      control_seen <= 1'b0;
      prg_slots[0] <= PRG_SLOT0_RESET;
      prg_slots[1] <= PRG_SLOT1_RESET;
      prg_slots[2] <= PRG_SLOT2_RESET;
      prg_slots[3] <= PRG_SLOT3_RESET;
      irq_counter  <= 8'd0;
      irq_latch    <= IRQ_LATCH_RESET;
      irq_enabled  <= 1'b0;
      mirror_flag  <= 1'b0;
      sram_flag    <= 1'b0;
    end else if (s1_go) begin
      control_byte <= control_byte_next;
      control_seen <= control_seen_next;
      prg_slots    <= prg_slots_next;
      irq_counter  <= irq_counter_next;
      irq_latch    <= irq_latch_next;
      irq_enabled  <= irq_enabled_next;
      mirror_flag  <= mirror_flag_next;
      sram_flag    <= sram_flag_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      prg_slot0         <= prg_slots_next[0];
      prg_slot1         <= prg_slots_next[1];
      prg_slot2         <= prg_slots_next[2];
      prg_slot3         <= prg_slots_next[3];
      chr_writes        <= chr_writes_next;
      chr_slot_first    <= chr_slot_first_next;
      chr_bank_first    <= chr_bank_first_next;
      chr_slot_second   <= chr_slot_second_next;
      chr_bank_second   <= chr_bank_second_next;
      mirror_horizontal <= mirror_flag_next;
      sram_enable       <= sram_flag_next;
      status            <= status_next;
    end
  end

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input side stalled while the result register could move");

  a_status_no_chr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_NONE) |-> (chr_writes == 2'd0))
    else $error("character assignment reported with an IRQ or fault status");

  a_chr_pair: assert property (@(posedge clk) disable iff (rst)
    (out_valid && chr_writes == 2'd2) |->
      (chr_slot_second == chr_slot_first + 3'd1 &&
       chr_bank_second == chr_bank_first + 8'd1))
    else $error("second character assignment does not follow the first");

  a_fault_keeps_slots: assert property (@(posedge clk) disable iff (rst)
    (s1_go && status_next == STATUS_FAULT) |=>
      (prg_slots[0] == $past(prg_slots[0]) && prg_slots[1] == $past(prg_slots[1]) &&
       prg_slots[2] == $past(prg_slots[2]) && prg_slots[3] == $past(prg_slots[3])))
    else $error("program slots changed on a data write before control");

endmodule

`default_nettype wire

### tb/tb_scanline_irq_bank_mapper_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for scanline_irq_bank_mapper_unit: directed bus writes and ticks,
// then random sequences under several program bank counts, with random stalls on both sides.
// Depends on sibm_pkg and the mapper RTL.

module tb_scanline_irq_bank_mapper_unit
  import sibm_pkg::*;
();

  typedef struct packed {
    logic        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [9:0]  line;
    logic        render;
  } bus_beat_t;

  typedef struct packed {
    logic [7:0] prg_slot0;
    logic [7:0] prg_slot1;
    logic [7:0] prg_slot2;
    logic [7:0] prg_slot3;
    logic [1:0] chr_writes;
    logic [2:0] chr_slot_first;
    logic [7:0] chr_bank_first;
    logic [2:0] chr_slot_second;
    logic [7:0] chr_bank_second;
    logic       mirror_horizontal;
    logic       sram_enable;
    logic [1:0] status;
  } mapper_result_t;

  typedef struct packed {
    bus_beat_t      beat;
    logic           typed;
    mapper_result_t want;
  } stim_row_t;

  // Results that follow straight from the reset state with a count of 32.
  localparam mapper_result_t WANT_IDLE = '{prg_slot0: 8'd0, prg_slot1: 8'd1,
    prg_slot2: 8'd30, prg_slot3: 8'd31, default: '0};
  localparam mapper_result_t WANT_FAULT = '{prg_slot0: 8'd0, prg_slot1: 8'd1,
    prg_slot2: 8'd30, prg_slot3: 8'd31, status: STATUS_FAULT, default: '0};
  localparam mapper_result_t WANT_CHR_WRAP = '{prg_slot0: 8'd0, prg_slot1: 8'd1,
    prg_slot2: 8'd30, prg_slot3: 8'd31, chr_writes: 2'd2, chr_slot_first: 3'd0,
    chr_bank_first: 8'hFF, chr_slot_second: 3'd1, chr_bank_second: 8'h00, default: '0};

  stim_row_t directed_rows [25] = '{
    '{'{CMD_WRITE, ADDR_DATA, 8'h55, 10'd0, 1'b0}, 1'b1, WANT_FAULT},
    '{'{CMD_TICK, 16'h0000, 8'h00, LINE_PRE_RENDER, 1'b1}, 1'b1, WANT_IDLE},
    '{'{CMD_WRITE, 16'h0000, 8'hFF, 10'd0, 1'b0}, 1'b1, WANT_IDLE},
    '{'{CMD_WRITE, 16'hFFFF, 8'h00, 10'd0, 1'b0}, 1'b1, WANT_IDLE},
    '{'{CMD_WRITE, ADDR_CONTROL, 8'h00, 10'd0, 1'b0}, 1'b1, WANT_IDLE},
    '{'{CMD_WRITE, ADDR_DATA, 8'hFF, 10'd0, 1'b0}, 1'b1, WANT_CHR_WRAP},
    '{'{CMD_WRITE, ADDR_CONTROL, 8'h81, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_DATA, 8'h10, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_CONTROL, 8'h02, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_DATA, 8'h00, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_CONTROL, 8'h06, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_DATA, 8'hFF, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_CONTROL, 8'h46, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_DATA, 8'h05, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_CONTROL, 8'hC7, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_DATA, 8'h03, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_MIRROR, 8'h01, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_SRAM, 8'hFF, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_IRQ_LATCH, 8'h05, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_IRQ_COUNT, 8'h02, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_IRQ_ON, 8'h00, 10'd0, 1'b0}, 1'b0, '0},
    '{'{CMD_TICK, 16'h0000, 8'h00, 10'd0, 1'b1}, 1'b0, '0},
    '{'{CMD_TICK, 16'h0000, 8'h00, 10'd239, 1'b1}, 1'b0, '0},
    '{'{CMD_TICK, 16'h0000, 8'h00, 10'd240, 1'b1}, 1'b0, '0},
    '{'{CMD_WRITE, ADDR_IRQ_OFF, 8'h00, 10'd0, 1'b0}, 1'b0, '0}
  };

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              command = 1'b0;
  logic [15:0]       address = '0;
  logic [7:0]        write_data = '0;
  logic signed [9:0] scanline = '0;
  logic              rendering_on = 1'b0;
  logic              out_ready = 1'b0;
  logic              cfg_we = 1'b0;
  logic [7:0]        cfg_wdata = '0;
  logic              in_ready;
  logic              out_valid;
  logic [7:0]        prg_slot0;
  logic [7:0]        prg_slot1;
  logic [7:0]        prg_slot2;
  logic [7:0]        prg_slot3;
  logic [1:0]        chr_writes;
  logic [2:0]        chr_slot_first;
  logic [7:0]        chr_bank_first;
  logic [2:0]        chr_slot_second;
  logic [7:0]        chr_bank_second;
  logic              mirror_horizontal;
  logic              sram_enable;
  logic [1:0]        status;

  scanline_irq_bank_mapper_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .address(address),
    .write_data(write_data),
    .scanline(scanline),
    .rendering_on(rendering_on),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .prg_slot0(prg_slot0),
    .prg_slot1(prg_slot1),
    .prg_slot2(prg_slot2),
    .prg_slot3(prg_slot3),
    .chr_writes(chr_writes),
    .chr_slot_first(chr_slot_first),
    .chr_bank_first(chr_bank_first),
    .chr_slot_second(chr_slot_second),
    .chr_bank_second(chr_bank_second),
    .mirror_horizontal(mirror_horizontal),
    .sram_enable(sram_enable),
    .status(status),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Mapper state as the testbench predicts it.
  logic [7:0] bank_count;
  logic [7:0] ctrl_byte;
  logic       ctrl_seen;
  logic [2:0] bank_cmd;
  logic [7:0] prg_map [4];
  logic [7:0] irq_count;
  logic [7:0] irq_reload;
  logic       irq_armed;
  logic       mirror_h;
  logic       sram_on;

  mapper_result_t expected_results [$];
  bus_beat_t      beat_plan [$];
  int             fail_count = 0;
  int             quiet_left = 0;
  int             ready_hold = 0;

  // Keep the widest run of low bits, from the full byte downwards, that lands below the count.
  function automatic logic [7:0] fold_to_count(input logic [7:0] bank);
    logic [7:0] mask;
    mask = 8'hFF;
    if (bank < bank_count) return bank;
    while (mask != 8'h00 && (bank & mask) >= bank_count) mask = mask >> 1;
    return bank & mask;
  endfunction

  function automatic void reset_mapper_state();
    bank_count = 8'd32;
    ctrl_byte  = '0;
    ctrl_seen  = 1'b0;
    bank_cmd   = '0;
    prg_map[0] = fold_to_count(8'd0);
    prg_map[1] = fold_to_count(8'd1);
    prg_map[2] = fold_to_count(bank_count - 8'd2);
    prg_map[3] = fold_to_count(bank_count - 8'd1);
    irq_count  = '0;
    irq_reload = 8'hFF;
    irq_armed  = 1'b0;
    mirror_h   = 1'b0;
    sram_on    = 1'b0;
  endfunction

  function automatic mapper_result_t apply_bus_beat(input bus_beat_t b);
    mapper_result_t    r;
    logic              chr_swap;
    logic              prg_swap;
    logic signed [9:0] line;
    r = '0;
    line = b.line;
    chr_swap = ctrl_byte[CTRL_CHR_SWAP_BIT];
    prg_swap = ctrl_byte[CTRL_PRG_SWAP_BIT];
    if (b.cmd == CMD_WRITE) begin
      case (b.addr)
        ADDR_CONTROL: begin
          ctrl_byte = b.data;
          bank_cmd  = b.data[2:0];
          ctrl_seen = 1'b1;
        end
        ADDR_DATA: begin
          if (!ctrl_seen) begin
            r.status = STATUS_FAULT;
          end else begin
            case (bank_cmd)
              BANK_CMD_CHR_2K_0, BANK_CMD_CHR_2K_1: begin
                r.chr_writes      = 2'd2;
                r.chr_slot_first  = {chr_swap, bank_cmd[0], 1'b0};
                r.chr_slot_second = {chr_swap, bank_cmd[0], 1'b1};
                r.chr_bank_first  = b.data;
                r.chr_bank_second = b.data + 8'd1;
              end
              BANK_CMD_CHR_1K_0, BANK_CMD_CHR_1K_1, BANK_CMD_CHR_1K_2, BANK_CMD_CHR_1K_3: begin
                // The 1K slots sit in the upper half unless the swap bit moves them down.
                r.chr_writes     = 2'd1;
                r.chr_slot_first = {!chr_swap, 2'(bank_cmd - BANK_CMD_CHR_1K_0)};
                r.chr_bank_first = b.data;
              end
              BANK_CMD_PRG_0: begin
                if (!prg_swap) begin
                  prg_map[0] = fold_to_count(b.data);
                  prg_map[2] = fold_to_count(bank_count - 8'd2);
                end else begin
                  prg_map[0] = fold_to_count(bank_count - 8'd2);
                  prg_map[2] = fold_to_count(b.data);
                end
                prg_map[3] = fold_to_count(bank_count - 8'd1);
              end
              default: begin
                prg_map[1] = fold_to_count(b.data);
                if (!prg_swap) prg_map[2] = fold_to_count(bank_count - 8'd2);
                else prg_map[0] = fold_to_count(bank_count - 8'd2);
                prg_map[3] = fold_to_count(bank_count - 8'd1);
              end
            endcase
          end
        end
        ADDR_MIRROR:    mirror_h = b.data[0];
        ADDR_SRAM:      sram_on = b.data[0];
        ADDR_IRQ_COUNT: irq_count = b.data;
        ADDR_IRQ_LATCH: irq_reload = b.data;
        ADDR_IRQ_OFF: begin
          irq_armed = 1'b0;
          irq_count = irq_reload;
        end
        ADDR_IRQ_ON:    irq_armed = 1'b1;
        default: ;
      endcase
    end else if (line == -10'sd1) begin
      irq_count = irq_reload;
    end else if (line >= 10'sd0 && line <= LINE_LAST_VISIBLE && irq_armed && b.render) begin
      irq_count = irq_count - 8'd1;
      if (irq_count == 8'd0) r.status = STATUS_IRQ;
    end
    r.prg_slot0 = prg_map[0];
    r.prg_slot1 = prg_map[1];
    r.prg_slot2 = prg_map[2];
    r.prg_slot3 = prg_map[3];
    r.mirror_horizontal = mirror_h;
    r.sram_enable = sram_on;
    return r;
  endfunction

  function automatic string fmt_result(input mapper_result_t r);
    return $sformatf("prg %0h/%0h/%0h/%0h chr %0d [%0d]=%0h [%0d]=%0h mir %0b sram %0b st %0d",
                     r.prg_slot0, r.prg_slot1, r.prg_slot2, r.prg_slot3, r.chr_writes,
                     r.chr_slot_first, r.chr_bank_first, r.chr_slot_second, r.chr_bank_second,
                     r.mirror_horizontal, r.sram_enable, r.status);
  endfunction

  function automatic bus_beat_t bus_write(input logic [15:0] addr, input logic [7:0] data);
    bus_beat_t b;
    b = '0;
    b.cmd  = CMD_WRITE;
    b.addr = addr;
    b.data = data;
    return b;
  endfunction

  function automatic bus_beat_t bus_tick(input int line, input logic render);
    bus_beat_t b;
    b = '0;
    b.cmd    = CMD_TICK;
    b.line   = 10'(line);
    b.render = render;
    return b;
  endfunction

  // Mostly well-formed traffic: control/data pairs, IRQ set-up and visible-line ticks.
  function automatic void add_random_sequence();
    int        r;
    int        pick;
    bus_beat_t b;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      beat_plan.push_back(bus_write(ADDR_CONTROL, 8'($urandom)));
      beat_plan.push_back(bus_write(ADDR_DATA, 8'($urandom)));
      if ($urandom_range(0, 3) == 0) beat_plan.push_back(bus_write(ADDR_DATA, 8'($urandom)));
    end else if (r < 45) begin
      beat_plan.push_back(bus_write(ADDR_DATA, 8'($urandom)));
    end else if (r < 70) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) b = bus_tick($urandom_range(0, 239), $urandom_range(0, 9) != 0);
      else if (pick < 90) b = bus_tick(-1, 1'($urandom));
      else b = bus_tick($urandom_range(240, 261), 1'($urandom));
      beat_plan.push_back(b);
    end else if (r < 80) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: beat_plan.push_back(bus_write(ADDR_IRQ_COUNT, 8'($urandom_range(0, 15))));
        1: beat_plan.push_back(bus_write(ADDR_IRQ_LATCH, 8'($urandom_range(0, 15))));
        2: beat_plan.push_back(bus_write(ADDR_IRQ_LATCH, 8'($urandom)));
        3: beat_plan.push_back(bus_write(ADDR_IRQ_OFF, 8'($urandom)));
        default: beat_plan.push_back(bus_write(ADDR_IRQ_ON, 8'($urandom)));
      endcase
    end else if (r < 88) begin
      b = bus_write($urandom_range(0, 1) ? ADDR_MIRROR : ADDR_SRAM, 8'($urandom));
      beat_plan.push_back(b);
    end else begin
      b.cmd    = 1'($urandom);
      b.addr   = 16'($urandom);
      b.data   = 8'($urandom);
      b.line   = 10'(int'($urandom_range(0, 262)) - 1);
      b.render = 1'($urandom);
      beat_plan.push_back(b);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(40, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_beat(input bus_beat_t b, input logic typed, input mapper_result_t want);
    mapper_result_t predicted;
    int             gap;
    in_valid     <= 1'b1;
    command      <= b.cmd;
    address      <= b.addr;
    write_data   <= b.data;
    scanline     <= b.line;
    rendering_on <= b.render;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_bus_beat(b);
    expected_results.push_back(typed ? want : predicted);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    int waited;
    waited = 0;
    while (expected_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      fail_count += expected_results.size();
      if (fail_count <= 10) $display("%0d results never arrived", expected_results.size());
      expected_results.delete();
    end
    // Let the input and result registers drain before touching the bank count register.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bank_count(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    bank_count = value;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    mapper_result_t got;
    mapper_result_t want;
    string          bad;
    int             r;
    if (!rst && out_valid && out_ready) begin
      got = '{prg_slot0, prg_slot1, prg_slot2, prg_slot3, chr_writes, chr_slot_first,
              chr_bank_first, chr_slot_second, chr_bank_second, mirror_horizontal,
              sram_enable, status};
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result with nothing expected: %s", fmt_result(got));
      end else begin
        want = expected_results.pop_front();
        bad = "";
        if (got.prg_slot0 !== want.prg_slot0) bad = {bad, " prg_slot0"};
        if (got.prg_slot1 !== want.prg_slot1) bad = {bad, " prg_slot1"};
        if (got.prg_slot2 !== want.prg_slot2) bad = {bad, " prg_slot2"};
        if (got.prg_slot3 !== want.prg_slot3) bad = {bad, " prg_slot3"};
        if (got.chr_writes !== want.chr_writes) bad = {bad, " chr_writes"};
        if (got.chr_slot_first !== want.chr_slot_first) bad = {bad, " chr_slot_first"};
        if (got.chr_bank_first !== want.chr_bank_first) bad = {bad, " chr_bank_first"};
        if (got.chr_slot_second !== want.chr_slot_second) bad = {bad, " chr_slot_second"};
        if (got.chr_bank_second !== want.chr_bank_second) bad = {bad, " chr_bank_second"};
        if (got.mirror_horizontal !== want.mirror_horizontal) bad = {bad, " mirror_horizontal"};
        if (got.sram_enable !== want.sram_enable) bad = {bad, " sram_enable"};
        if (got.status !== want.status) bad = {bad, " status"};
        if (bad != "") begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch in%s", bad);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
        end
      end
    end
    // Receiver back-pressure: short stalls mostly, some long ones, and long open stretches.
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(1, 8);
      end else if (r < 70) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(100, 300);
      end else if (r < 92) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end
  end

  initial begin
    logic [7:0] phase_counts [6];
    phase_counts = '{8'd255, 8'd2, 8'd0, 8'd3, 8'd129, 8'd0};
    phase_counts[2] = 8'($urandom_range(2, 255));
    phase_counts[5] = 8'($urandom_range(2, 255));
    reset_mapper_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_bank_count(8'd32);
    for (int i = 0; i < $size(directed_rows); i++) begin
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
    end
    for (int p = 0; p < 6; p++) begin
      // Drop valid first so the last beat of the previous run is not taken again.
      in_valid <= 1'b0;
      wait_for_results();
      write_bank_count(phase_counts[p]);
      beat_plan.delete();
      while (beat_plan.size() < 250) add_random_sequence();
      foreach (beat_plan[i]) send_beat(beat_plan[i], 1'b0, '0);
    end
    in_valid <= 1'b0;
    wait_for_results();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

### scanline_irq_bank_mapper_unit.f
src/sibm_pkg.sv
src/scanline_irq_bank_mapper_unit.sv
tb/tb_scanline_irq_bank_mapper_unit.sv
